/* hw/rtl/trrp_pkg.sv */
// Shared types, codes and the zero-width character table for the Thai row redraw planner.
// Used by every module of the block; depends on nothing else.
package trrp_pkg;

    // Request codes carried on i_func.
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_COMPARE = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    // Display cell states held in the cell store.
    localparam logic [1:0] MARK_SAME      = 2'd0;
    localparam logic [1:0] MARK_UNREACHED = 2'd1;
    localparam logic [1:0] MARK_REACHED   = 2'd2;

    // Character and counter constants.
    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [7:0] NUL_BYTE    = 8'h00;
    localparam logic [3:0] SPACE_MAX   = 4'd15;
    localparam logic [3:0] SPACE_RESET = 4'd2;

    // One display cell: bases and mark sums of both rows, plus its state.
    typedef struct packed {
        logic [1:0]  mark;
        logic [31:0] new_base;
        logic [31:0] new_sum;
        logic [31:0] old_base;
        logic [31:0] old_sum;
    } t_cell_word;

    // Control group for one store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_mem_ctrl;

    // Marks the bytes that take no cell of their own (combining vowels,
    // tone marks and most control bytes).
    function automatic logic is_zero_width(input logic [7:0] c);
        logic zw;
        case (c) inside
            [8'h01:8'h08], [8'h0A:8'h1A], [8'h1C:8'h1F],
            8'hD1, [8'hD4:8'hDB], [8'hE7:8'hEE]: zw = 1'b1;
            default:                             zw = 1'b0;
        endcase
        return zw;
    endfunction

endpackage

/* hw/rtl/trrp_vmem.sv */
// Synchronous single-read, single-write store with per-entry valid bits.
// Entries that are not valid read as zero; clr empties the whole store at once.
// Uses trrp_pkg for the control group type.
module trrp_vmem #(
    parameter int unsigned DEPTH = 81,
    parameter int unsigned WIDTH = 130,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trrp_pkg::t_mem_ctrl i_ctrl,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [WIDTH-1:0]    i_wr_data,
    output logic [WIDTH-1:0]    o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_hit;

    // Storage array write port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the valid bit is sampled with the data.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_hit  <= r_valid[i_rd_addr];
        end
    end

    // Valid bits: cleared by reset or by a row clear, set on write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctrl.clr) begin
            r_valid <= '0;
        end else if (i_ctrl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

/* hw/rtl/trrp_advance.sv */
// Cell pointer advance for one row: owed zero-width count, space run and pointer clamp.
// Purely combinational; uses trrp_pkg for the character table and constants.
module trrp_advance #(
    parameter int unsigned NCOL = 80,
    localparam int unsigned PW  = $clog2(NCOL + 1)
) (
    input  logic [7:0]    i_char,
    input  logic [PW-1:0] i_ptr,
    input  logic [PW-1:0] i_owed,
    input  logic [3:0]    i_spaces,
    input  logic [3:0]    i_space_count,
    output logic [PW-1:0] o_ptr,
    output logic [PW-1:0] o_owed,
    output logic [3:0]    o_spaces
);

    logic [PW:0]  adv;
    logic [PW:0]  sum;
    logic [3:0]   spaces_inc;

    assign spaces_inc = (i_spaces != trrp_pkg::SPACE_MAX) ? i_spaces + 4'd1 : i_spaces;

    // Classify the byte and work out how many cells it moves the pointer.
    always_comb begin
        adv      = '0;
        o_owed   = i_owed;
        o_spaces = i_spaces;
        if (i_char == trrp_pkg::NUL_BYTE) begin
            o_owed   = '0;
            o_spaces = '0;
        end else if (trrp_pkg::is_zero_width(i_char)) begin
            o_owed   = (i_owed != '1) ? i_owed + PW'(1) : i_owed;
            o_spaces = '0;
        end else if (i_char != trrp_pkg::SPACE_BYTE) begin
            o_spaces = '0;
            adv      = (PW + 1)'(1);
        end else if (spaces_inc == i_space_count) begin
            // The run is complete: pay the owed cells along with this space.
            adv      = {1'b0, i_owed} + (PW + 1)'(1);
            o_owed   = '0;
            o_spaces = '0;
        end else begin
            o_spaces = spaces_inc;
            adv      = (PW + 1)'(1);
        end
    end

    // The pointer never passes the last display cell.
    assign sum   = {1'b0, i_ptr} + adv;
    assign o_ptr = (sum > (PW + 1)'(NCOL)) ? PW'(NCOL) : sum[PW-1:0];

endmodule

/* hw/rtl/thai_row_redraw_planner.sv */
// Top level of the Thai row redraw planner: request sequencer, row counters and outputs.
// Depends on trrp_pkg, trrp_vmem (cell and column stores) and trrp_advance.
//
// Channel   Direction  Beat taken when             Carries
// request   in         start && !busy              i_func, chars, renditions, i_col_index
// result    out        o_done (one cycle, no hold) redraw, cell_mark, counts
// config    in         i_cfg_valid && o_cfg_ready  i_cfg_data (space_count)
//
// A load keeps busy high through S_LD_RDN, S_LD_WRN, S_LD_RDO and S_LD_WRO;
// one cell store port serves the read-modify-write of the new row, then of the old row.
// A compare keeps busy high while it marks each cell, then follows each column to
// its cell. The result shows as busy falls.
// A read keeps busy high through S_RD_OUT; its result shows as busy falls.
// Loads beyond NCOL columns and unused request codes leave busy low and give no result.
// Reset is synchronous; the stores need no clearing pass, as valid bits empty them.
module thai_row_redraw_planner #(
    parameter int unsigned NCOL = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_new_char,
    input  logic [31:0] i_new_rend,
    input  logic [7:0]  i_old_char,
    input  logic [31:0] i_old_rend,
    input  logic [6:0]  i_col_index,
    // Result channel
    output logic        o_done,
    output logic        o_redraw,
    output logic [1:0]  o_cell_mark,
    output logic [6:0]  o_unclaimed_count,
    output logic [6:0]  o_text_width,
    // Configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    localparam int unsigned PW   = $clog2(NCOL + 1);
    localparam int unsigned CAW  = (NCOL > 1) ? $clog2(NCOL) : 1;
    localparam int unsigned IXW  = (PW > 7) ? PW : 7;
    localparam int unsigned CW   = $bits(trrp_pkg::t_cell_word);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RDN,
        S_LD_WRN,
        S_LD_RDO,
        S_LD_WRO,
        S_C1_RD,
        S_C1_WR,
        S_C2_RDC,
        S_C2_RDM,
        S_C2_WR,
        S_RD_OUT
    } t_state;

    t_state r_state, n_state;

    logic [PW-1:0] r_load_pos, n_load_pos;
    logic [PW-1:0] r_ptr_new, n_ptr_new, r_ptr_old, n_ptr_old;
    logic [PW-1:0] r_owed_new, n_owed_new, r_owed_old, n_owed_old;
    logic [3:0]    r_spaces_new, n_spaces_new, r_spaces_old, n_spaces_old;
    logic [PW-1:0] r_width, n_width;
    logic [PW-1:0] r_unclaimed, n_unclaimed;
    logic [PW-1:0] r_cnt, n_cnt;
    logic [3:0]    r_space_count;
    logic          r_done, n_done;
    logic          r_redraw, n_redraw;
    logic [1:0]    r_mark, n_mark;
    logic          r_col_ok, n_col_ok, r_cell_ok, n_cell_ok;
    logic [PW:0]   r_colw, n_colw;

    // Payload registers, captured at the request beat.
    logic [7:0]    r_nc, r_oc;
    logic [31:0]   r_nval, r_oval;

    logic          accept;
    logic [IXW-1:0] idx_ext;

    // Store interfaces.
    trrp_pkg::t_mem_ctrl  cell_ctrl, col_ctrl;
    logic [PW-1:0]        cell_rd_addr, cell_wr_addr;
    trrp_pkg::t_cell_word cell_wr_word, cell_rd_word;
    logic [CW-1:0]        cell_rd_bits;
    logic [CAW-1:0]       col_rd_addr, col_wr_addr;
    logic [PW:0]          col_wr_data, col_rd_data;

    // Advance units for both rows.
    logic [PW-1:0] a_ptr_new, a_owed_new, a_ptr_old, a_owed_old;
    logic [3:0]    a_spaces_new, a_spaces_old;
    logic          cell_diff;

    trrp_advance #(.NCOL(NCOL)) u_adv_new (
        .i_char        (r_nc),
        .i_ptr         (r_ptr_new),
        .i_owed        (r_owed_new),
        .i_spaces      (r_spaces_new),
        .i_space_count (r_space_count),
        .o_ptr         (a_ptr_new),
        .o_owed        (a_owed_new),
        .o_spaces      (a_spaces_new)
    );

    trrp_advance #(.NCOL(NCOL)) u_adv_old (
        .i_char        (r_oc),
        .i_ptr         (r_ptr_old),
        .i_owed        (r_owed_old),
        .i_spaces      (r_spaces_old),
        .i_space_count (r_space_count),
        .o_ptr         (a_ptr_old),
        .o_owed        (a_owed_old),
        .o_spaces      (a_spaces_old)
    );

    // Cell store: one entry per display cell, cell 0 included.
    trrp_vmem #(.DEPTH(NCOL + 1), .WIDTH(CW)) u_cell_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (cell_ctrl),
        .i_rd_addr (cell_rd_addr),
        .i_wr_addr (cell_wr_addr),
        .i_wr_data (cell_wr_word),
        .o_rd_data (cell_rd_bits)
    );

    assign cell_rd_word = cell_rd_bits;

    // Column store: redraw flag over the cell that each source column lands on.
    trrp_vmem #(.DEPTH(NCOL), .WIDTH(PW + 1)) u_col_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (col_ctrl),
        .i_rd_addr (col_rd_addr),
        .i_wr_addr (col_wr_addr),
        .i_wr_data (col_wr_data),
        .o_rd_data (col_rd_data)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign idx_ext     = IXW'(i_col_index);

    // A cell changed when either field differs or the new base is empty.
    assign cell_diff = (cell_rd_word.new_base != cell_rd_word.old_base) ||
                       (cell_rd_word.new_sum != cell_rd_word.old_sum) ||
                       (cell_rd_word.new_base == '0);

    // Next-state logic and store accesses for every request.
    always_comb begin
        n_state      = r_state;
        n_load_pos   = r_load_pos;
        n_ptr_new    = r_ptr_new;
        n_ptr_old    = r_ptr_old;
        n_owed_new   = r_owed_new;
        n_owed_old   = r_owed_old;
        n_spaces_new = r_spaces_new;
        n_spaces_old = r_spaces_old;
        n_width      = r_width;
        n_unclaimed  = r_unclaimed;
        n_cnt        = r_cnt;
        n_done       = 1'b0;
        n_redraw     = r_redraw;
        n_mark       = r_mark;
        n_col_ok     = r_col_ok;
        n_cell_ok    = r_cell_ok;
        n_colw       = r_colw;

        cell_ctrl    = '0;
        col_ctrl     = '0;
        cell_rd_addr = r_cnt;
        cell_wr_addr = r_cnt;
        cell_wr_word = cell_rd_word;
        col_rd_addr  = r_cnt[CAW-1:0];
        col_wr_addr  = r_cnt[CAW-1:0];
        col_wr_data  = r_colw;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        trrp_pkg::FUNC_LOAD: begin
                            if (r_load_pos < PW'(NCOL)) begin
                                // The first column of a row empties every store.
                                if (r_load_pos == '0) begin
                                    cell_ctrl.clr = 1'b1;
                                    col_ctrl.clr  = 1'b1;
                                    n_ptr_new     = '0;
                                    n_ptr_old     = '0;
                                    n_owed_new    = '0;
                                    n_owed_old    = '0;
                                    n_spaces_new  = '0;
                                    n_spaces_old  = '0;
                                    n_width       = '0;
                                    n_unclaimed   = '0;
                                end
                                n_state = S_LD_RDN;
                            end
                        end
                        trrp_pkg::FUNC_COMPARE: begin
                            n_unclaimed = '0;
                            n_cnt       = PW'(1);
                            n_state     = S_C1_RD;
                        end
                        trrp_pkg::FUNC_READ: begin
                            n_col_ok       = idx_ext < IXW'(NCOL);
                            n_cell_ok      = idx_ext <= IXW'(NCOL);
                            col_ctrl.rd_en = idx_ext < IXW'(NCOL);
                            cell_ctrl.rd_en = idx_ext <= IXW'(NCOL);
                            col_rd_addr    = idx_ext[CAW-1:0];
                            cell_rd_addr   = idx_ext[PW-1:0];
                            n_state        = S_RD_OUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Load: move both pointers, record the column and fetch the new cell.
            S_LD_RDN: begin
                n_ptr_new       = a_ptr_new;
                n_owed_new      = a_owed_new;
                n_spaces_new    = a_spaces_new;
                n_ptr_old       = a_ptr_old;
                n_owed_old      = a_owed_old;
                n_spaces_old    = a_spaces_old;
                n_width         = a_ptr_new;
                col_ctrl.wr_en  = 1'b1;
                col_wr_addr     = r_load_pos[CAW-1:0];
                col_wr_data     = {1'b0, a_ptr_new};
                n_load_pos      = r_load_pos + PW'(1);
                cell_ctrl.rd_en = 1'b1;
                cell_rd_addr    = a_ptr_new;
                n_state         = S_LD_WRN;
            end

            S_LD_WRN: begin
                cell_ctrl.wr_en = 1'b1;
                cell_wr_addr    = r_ptr_new;
                if (trrp_pkg::is_zero_width(r_nc)) begin
                    cell_wr_word.new_sum = cell_rd_word.new_sum + r_nval;
                end else begin
                    cell_wr_word.new_base = r_nval;
                end
                n_state = S_LD_RDO;
            end

            S_LD_RDO: begin
                cell_ctrl.rd_en = 1'b1;
                cell_rd_addr    = r_ptr_old;
                n_state         = S_LD_WRO;
            end

            S_LD_WRO: begin
                cell_ctrl.wr_en = 1'b1;
                cell_wr_addr    = r_ptr_old;
                if (trrp_pkg::is_zero_width(r_oc)) begin
                    cell_wr_word.old_sum = cell_rd_word.old_sum + r_oval;
                end else begin
                    cell_wr_word.old_base = r_oval;
                end
                n_state = S_IDLE;
            end

            // Compare, first pass: mark each display cell 1..NCOL.
            S_C1_RD: begin
                cell_ctrl.rd_en = 1'b1;
                n_state         = S_C1_WR;
            end

            S_C1_WR: begin
                cell_ctrl.wr_en   = 1'b1;
                cell_wr_word.mark = cell_diff ? trrp_pkg::MARK_UNREACHED
                                              : trrp_pkg::MARK_SAME;
                n_unclaimed       = r_unclaimed + PW'(cell_diff);
                if (r_cnt == PW'(NCOL)) begin
                    n_cnt   = '0;
                    n_state = S_C2_RDC;
                end else begin
                    n_cnt   = r_cnt + PW'(1);
                    n_state = S_C1_RD;
                end
            end

            // Compare, second pass: follow each column to its cell.
            S_C2_RDC: begin
                col_ctrl.rd_en = 1'b1;
                n_state        = S_C2_RDM;
            end

            S_C2_RDM: begin
                n_colw          = col_rd_data;
                cell_ctrl.rd_en = 1'b1;
                cell_rd_addr    = col_rd_data[PW-1:0];
                n_state         = S_C2_WR;
            end

            S_C2_WR: begin
                col_ctrl.wr_en = 1'b1;
                col_wr_data    = {(cell_rd_word.mark != trrp_pkg::MARK_SAME),
                                  r_colw[PW-1:0]};
                cell_wr_addr   = r_colw[PW-1:0];
                if (cell_rd_word.mark == trrp_pkg::MARK_UNREACHED) begin
                    cell_ctrl.wr_en   = 1'b1;
                    cell_wr_word.mark = trrp_pkg::MARK_REACHED;
                    n_unclaimed       = r_unclaimed - PW'(1);
                end
                if (r_cnt == PW'(NCOL - 1)) begin
                    n_load_pos = '0;
                    n_redraw   = 1'b0;
                    n_mark     = trrp_pkg::MARK_SAME;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + PW'(1);
                    n_state = S_C2_RDC;
                end
            end

            // Read: both stores answer in the cycle after the request beat.
            S_RD_OUT: begin
                n_redraw = r_col_ok && col_rd_data[PW];
                n_mark   = r_cell_ok ? cell_rd_word.mark : trrp_pkg::MARK_SAME;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, counters and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_load_pos    <= '0;
            r_ptr_new     <= '0;
            r_ptr_old     <= '0;
            r_owed_new    <= '0;
            r_owed_old    <= '0;
            r_spaces_new  <= '0;
            r_spaces_old  <= '0;
            r_width       <= '0;
            r_unclaimed   <= '0;
            r_cnt         <= '0;
            r_done        <= 1'b0;
            r_redraw      <= 1'b0;
            r_mark        <= trrp_pkg::MARK_SAME;
            r_col_ok      <= 1'b0;
            r_cell_ok     <= 1'b0;
            r_space_count <= trrp_pkg::SPACE_RESET;
        end else begin
            r_state      <= n_state;
            r_load_pos   <= n_load_pos;
            r_ptr_new    <= n_ptr_new;
            r_ptr_old    <= n_ptr_old;
            r_owed_new   <= n_owed_new;
            r_owed_old   <= n_owed_old;
            r_spaces_new <= n_spaces_new;
            r_spaces_old <= n_spaces_old;
            r_width      <= n_width;
            r_unclaimed  <= n_unclaimed;
            r_cnt        <= n_cnt;
            r_done       <= n_done;
            r_redraw     <= n_redraw;
            r_mark       <= n_mark;
            r_col_ok     <= n_col_ok;
            r_cell_ok    <= n_cell_ok;
            if (i_cfg_valid && o_cfg_ready) begin
                r_space_count <= i_cfg_data;
            end
        end
    end

    // Payload capture; the byte-plus-rendition sums are formed here once.
    always_ff @(posedge i_clk) begin
        r_colw <= n_colw;
        if (accept) begin
            r_nc   <= i_new_char;
            r_oc   <= i_old_char;
            r_nval <= {24'd0, i_new_char} + i_new_rend;
            r_oval <= {24'd0, i_old_char} + i_old_rend;
        end
    end

    // Result ports; counts are shown modulo 128.
    localparam int unsigned OXW = (PW > 7) ? PW : 7;
    logic [OXW-1:0] unclaimed_ext, width_ext;

    assign unclaimed_ext     = OXW'(r_unclaimed);
    assign width_ext         = OXW'(r_width);
    assign o_done            = r_done;
    assign o_redraw          = r_redraw;
    assign o_cell_mark       = r_mark;
    assign o_unclaimed_count = unclaimed_ext[6:0];
    assign o_text_width      = width_ext[6:0];

    // A load that is taken always occupies the sequencer in the next cycle.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == trrp_pkg::FUNC_LOAD) && (r_load_pos < PW'(NCOL))) |=> busy)
        else $error("load beat did not start the load sequence");

    // Both cell pointers stay on the row.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr_new <= PW'(NCOL)) && (r_ptr_old <= PW'(NCOL)))
        else $error("cell pointer beyond the last display cell");

    // A row clear never coincides with a store write.
    a_clr_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cell_ctrl.clr && cell_ctrl.wr_en) && !(col_ctrl.clr && col_ctrl.wr_en))
        else $error("store cleared and written in the same cycle");

    // A result is a single-cycle strobe.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for more than one cycle");

endmodule
